>>> hw/rtl/dtcm_pkg.sv
// Shared types and constants for the depot TSP cost matrix entry block.
// No dependencies; imported by every module of the block.
package dtcm_pkg;

    // Field widths
    localparam int NODE_W    = 10;
    localparam int COORD_W   = 20;
    localparam int DEPOT_W   = 9;
    localparam int CUST_W    = 10;
    localparam int CNT_W     = 12;  // holds depots + customers + depots
    localparam int WEIGHT_W  = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 10;

    // Fixed-point distance datapath
    localparam int FRAC_BITS = 4;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int D2_W      = SQ_W + 1;
    localparam int SCALE_W   = 14;
    localparam int S_W       = D2_W + SCALE_W;
    localparam int RAD_W     = S_W + 3;           // room for 4*S, even width
    localparam int ROOT_W    = RAD_W / 2;
    localparam int REM_W     = ROOT_W + 2;
    localparam int RES_W     = ROOT_W + 1;

    localparam logic [SCALE_W-1:0]  SCALE_SQ    = 14'd10000;
    localparam logic [WEIGHT_W-1:0] FORBID_W    = 24'd1000000;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX  = 24'hFFFFFF;

    // Entry kind codes
    typedef enum logic [1:0] {
        KIND_DIST   = 2'd0,
        KIND_ZERO   = 2'd1,
        KIND_FORBID = 2'd2
    } t_kind;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEPOT = 2'd0,
        CFG_CUST  = 2'd1,
        CFG_ROUND = 2'd2
    } t_cfg_idx;

    // Data handed from cell to cell along the square-root chain
    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic              rnd;
        t_kind             kind;
    } t_sq;

endpackage

>>> hw/rtl/dtcm_front.sv
// Front end: entry classification, coordinate differences, squares and
// scaling into the square-root radicand. Four elastic stages.
// Depends on dtcm_pkg.
module dtcm_front
    import dtcm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [DEPOT_W-1:0]      i_depot_count,
    input  logic [CUST_W-1:0]       i_customer_count,
    input  logic                    i_round_nearest,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [NODE_W-1:0]       i_row_node,
    input  logic [NODE_W-1:0]       i_col_node,
    input  logic signed [COORD_W-1:0] i_row_x,
    input  logic signed [COORD_W-1:0] i_row_y,
    input  logic signed [COORD_W-1:0] i_col_x,
    input  logic signed [COORD_W-1:0] i_col_y,
    output logic                    o_valid,
    output t_sq                     o_data,
    input  logic                    i_ready
);

    logic r_v1, r_v2, r_v3, r_v4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    logic signed [DIFF_W-1:0] r_dx, r_dy;
    logic [SQ_W-1:0]          r_sqx, r_sqy;
    logic [D2_W-1:0]          r_d2;
    logic [RAD_W-1:0]         r_rad;
    logic                     r_rnd1, r_rnd2, r_rnd3, r_rnd4;
    t_kind                    r_k1, r_k2, r_k3, r_k4;

    // Stage readiness: a stage takes data when empty or draining
    assign w_rdy4  = !r_v4 || i_ready;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    // Node classification
    logic [CNT_W-1:0] w_d, w_k, w_dim, w_i, w_j, w_i1;
    logic w_iv, w_it, w_im, w_jt, w_jm, w_in_range, w_dist, w_zero;
    t_kind w_kind;

    always_comb begin
        w_d   = CNT_W'(i_depot_count);
        w_k   = w_d + CNT_W'(i_customer_count);
        w_dim = w_k + w_d;
        w_i   = CNT_W'(i_row_node);
        w_j   = CNT_W'(i_col_node);
        w_i1  = w_i + CNT_W'(1);
        w_iv  = w_i < w_d;
        w_it  = (w_i >= w_d) && (w_i < w_k);
        w_im  = w_i >= w_k;
        w_jt  = (w_j >= w_d) && (w_j < w_k);
        w_jm  = w_j >= w_k;
        w_in_range = (w_i < w_dim) && (w_j < w_dim);
        w_dist = (w_it && (w_jm || w_jt)) || (w_iv && w_jt);
        // own copy, copy to next depot, last node back to node 0
        w_zero = (w_iv && (w_j == w_i + w_k))
              || (w_im && (w_i1 < w_dim) && (w_j + w_k == w_i1))
              || ((w_i1 == w_dim) && (w_j == '0));
        if (!w_in_range) begin
            w_kind = KIND_FORBID;
        end else if (w_dist) begin
            w_kind = KIND_DIST;
        end else if (w_zero) begin
            w_kind = KIND_ZERO;
        end else begin
            w_kind = KIND_FORBID;
        end
    end

    // Products
    logic signed [2*DIFF_W-1:0] w_px, w_py;
    logic [S_W-1:0]             w_s;

    assign w_px = r_dx * r_dx;
    assign w_py = r_dy * r_dy;
    assign w_s  = S_W'(r_d2) * S_W'(SCALE_SQ);

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    // Payload stages
    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_dx   <= DIFF_W'(i_row_x) - DIFF_W'(i_col_x);
            r_dy   <= DIFF_W'(i_row_y) - DIFF_W'(i_col_y);
            r_rnd1 <= i_round_nearest;
            r_k1   <= w_kind;
        end
        if (w_rdy2) begin
            r_sqx  <= w_px[SQ_W-1:0];
            r_sqy  <= w_py[SQ_W-1:0];
            r_rnd2 <= r_rnd1;
            r_k2   <= r_k1;
        end
        if (w_rdy3) begin
            r_d2   <= D2_W'(r_sqx) + D2_W'(r_sqy);
            r_rnd3 <= r_rnd2;
            r_k3   <= r_k2;
        end
        if (w_rdy4) begin
            // nearest rounding works on sqrt(4*S)
            r_rad  <= r_rnd3 ? RAD_W'({w_s, 2'b00}) : RAD_W'(w_s);
            r_rnd4 <= r_rnd3;
            r_k4   <= r_k3;
        end
    end

    assign o_valid     = r_v4;
    assign o_data.rad  = r_rad;
    assign o_data.rem  = '0;
    assign o_data.root = '0;
    assign o_data.rnd  = r_rnd4;
    assign o_data.kind = r_k4;

endmodule

>>> hw/rtl/dtcm_sqrt_cell.sv
// One cell of the square-root chain: takes two radicand bits, yields one
// root bit and hands the partial result to the next cell.
// Depends on dtcm_pkg.
module dtcm_sqrt_cell
    import dtcm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sq  i_data,
    output logic o_valid,
    output t_sq  o_data,
    input  logic i_ready
);

    logic r_valid;
    t_sq  r_data;
    t_sq  n_data;

    logic [REM_W+1:0] w_rem_sh, w_trial;
    logic             w_ge;

    assign o_ready = !r_valid || i_ready;

    // Restoring square-root step
    always_comb begin
        w_rem_sh = {i_data.rem, i_data.rad[RAD_W-1 -: 2]};
        w_trial  = (REM_W+2)'({i_data.root, 2'b01});
        w_ge     = w_rem_sh >= w_trial;
        n_data   = i_data;
        n_data.rad  = {i_data.rad[RAD_W-3:0], 2'b00};
        n_data.rem  = w_ge ? REM_W'(w_rem_sh - w_trial) : REM_W'(w_rem_sh);
        n_data.root = {i_data.root[ROOT_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> hw/rtl/dtcm_finish.sv
// Output stage: rounds the root to the scaled distance, saturates, picks
// the entry weight by kind and holds the result for the receiver.
// Depends on dtcm_pkg.
module dtcm_finish
    import dtcm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  t_sq                 i_data,
    output logic                o_valid,
    output logic [WEIGHT_W-1:0] o_weight,
    output logic [1:0]          o_entry_kind,
    input  logic                i_ready
);

    logic                r_valid;
    logic [WEIGHT_W-1:0] r_weight;
    t_kind               r_kind;
    logic [WEIGHT_W-1:0] n_weight;

    logic [RES_W-1:0] w_near, w_ceil_t, w_ceil, w_v;

    assign o_ready = !r_valid || i_ready;

    // Rounding: nearest uses floor(sqrt(4S)), ceiling uses exactness of sqrt(S)
    always_comb begin
        w_near   = (RES_W'(i_data.root >> FRAC_BITS) + RES_W'(1)) >> 1;
        w_ceil_t = RES_W'(i_data.root) + RES_W'(i_data.rem != '0);
        w_ceil   = (w_ceil_t + RES_W'((1 << FRAC_BITS) - 1)) >> FRAC_BITS;
        w_v      = i_data.rnd ? w_near : w_ceil;
        case (i_data.kind)
            KIND_DIST: begin
                n_weight = (w_v > RES_W'(WEIGHT_MAX)) ? WEIGHT_MAX : w_v[WEIGHT_W-1:0];
            end
            KIND_ZERO: begin
                n_weight = '0;
            end
            default: begin
                n_weight = FORBID_W;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_weight <= n_weight;
            r_kind   <= i_data.kind;
        end
    end

    assign o_valid      = r_valid;
    assign o_weight     = r_weight;
    assign o_entry_kind = r_kind;

endmodule

>>> hw/rtl/depot_tsp_cost_matrix_entry_top.sv
// Top level of the depot TSP cost matrix entry block: configuration
// registers, front end, square-root cell chain and output stage.
// Depends on dtcm_pkg, dtcm_front, dtcm_sqrt_cell, dtcm_finish.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one request: row and
//   column node indices and both nodes' coordinates (4 fraction bits).
//   Output channel (o_out_valid / i_out_ready) returns one entry per
//   request, in order: o_weight and o_entry_kind (0 distance, 1 zero
//   link, 2 forbidden).
//   Config channel (i_cfg_valid / o_cfg_ready, always ready) writes depot
//   count (index 0), customer count (1) and rounding mode (2); write only
//   while no request is in flight.
// Timing:
//   Pipeline: 4 front stages, 29 square-root cells (one root bit each) and
//   the output register. Throughput is one request per cycle unless the
//   output stalls; every stage is a register.
// Stall: each stage holds its data while the next is full, so bubbles
//   fill up and o_in_ready drops only when every stage is occupied.
// Reset: synchronous, active low; clears all valid bits and sets the
//   registers to one depot, one customer, round up.
module depot_tsp_cost_matrix_entry_top
    import dtcm_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DAT_W-1:0]      i_cfg_data,
    // request channel
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [NODE_W-1:0]         i_row_node,
    input  logic [NODE_W-1:0]         i_col_node,
    input  logic signed [COORD_W-1:0] i_row_x,
    input  logic signed [COORD_W-1:0] i_row_y,
    input  logic signed [COORD_W-1:0] i_col_x,
    input  logic signed [COORD_W-1:0] i_col_y,
    // result channel
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [WEIGHT_W-1:0]       o_weight,
    output logic [1:0]                o_entry_kind
);

    logic [DEPOT_W-1:0] r_depot_count;
    logic [CUST_W-1:0]  r_customer_count;
    logic               r_round_nearest;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depot_count    <= DEPOT_W'(1);
            r_customer_count <= CUST_W'(1);
            r_round_nearest  <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DEPOT: r_depot_count    <= i_cfg_data[DEPOT_W-1:0];
                CFG_CUST:  r_customer_count <= i_cfg_data[CUST_W-1:0];
                CFG_ROUND: r_round_nearest  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Chain links: index 0 is the front end output, ROOT_W feeds the finish
    logic w_cv   [0:ROOT_W];
    logic w_crdy [0:ROOT_W];
    t_sq  w_cd   [0:ROOT_W];

    dtcm_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_depot_count    (r_depot_count),
        .i_customer_count (r_customer_count),
        .i_round_nearest  (r_round_nearest),
        .i_valid          (i_in_valid),
        .o_ready          (o_in_ready),
        .i_row_node       (i_row_node),
        .i_col_node       (i_col_node),
        .i_row_x          (i_row_x),
        .i_row_y          (i_row_y),
        .i_col_x          (i_col_x),
        .i_col_y          (i_col_y),
        .o_valid          (w_cv[0]),
        .o_data           (w_cd[0]),
        .i_ready          (w_crdy[0])
    );

    // Square-root cells, one root bit per cell
    for (genvar g = 0; g < ROOT_W; g++) begin : g_cell
        dtcm_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_cv[g]),
            .o_ready (w_crdy[g]),
            .i_data  (w_cd[g]),
            .o_valid (w_cv[g+1]),
            .o_data  (w_cd[g+1]),
            .i_ready (w_crdy[g+1])
        );
    end

    dtcm_finish u_finish (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_cv[ROOT_W]),
        .o_ready      (w_crdy[ROOT_W]),
        .i_data       (w_cd[ROOT_W]),
        .o_valid      (o_out_valid),
        .o_weight     (o_weight),
        .o_entry_kind (o_entry_kind),
        .i_ready      (i_out_ready)
    );

    // Checks
    a_zero_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_entry_kind == KIND_ZERO) |-> (o_weight == '0))
        else $error("zero link with nonzero weight");

    a_forbid_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_entry_kind == KIND_FORBID) |-> (o_weight == FORBID_W))
        else $error("forbidden entry with wrong weight");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("request side stalled while output can drain");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule
